// ----- rtl/rhlt_pkg.sv -----
// Shared constants for the Robin Hood lock table.
`timescale 1ns / 1ps
package rhlt_pkg;
	localparam int KEY_W   = 48;
	localparam int OWNIN_W = 16;
	localparam int SIZE_W  = 9;
	localparam int STAT_W  = 3;
	localparam int CNT_W   = 32;

	localparam logic [1:0] ACT_LOCK   = 2'd0;
	localparam logic [1:0] ACT_UNLOCK = 2'd1;
	localparam logic [1:0] ACT_SEARCH = 2'd2;

	localparam logic [STAT_W-1:0] ST_ACQUIRED = 3'd0;
	localparam logic [STAT_W-1:0] ST_HELD     = 3'd1;
	localparam logic [STAT_W-1:0] ST_CONFLICT = 3'd2;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
	localparam logic [STAT_W-1:0] ST_RELEASED = 3'd4;
	localparam logic [STAT_W-1:0] ST_NOT_HELD = 3'd5;
	localparam logic [STAT_W-1:0] ST_FOUND    = 3'd6;
	localparam logic [STAT_W-1:0] ST_MISSING  = 3'd7;
endpackage

// ----- rtl/rhlt_mod.sv -----
// Bit-serial remainder unit: key modulo table size, one dividend bit per cycle.
`timescale 1ns / 1ps
module rhlt_mod import rhlt_pkg::*; #(
	parameter int DW = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [KEY_W-1:0]  dividend,
	input  logic [DW-1:0]     divisor,
	output logic              done,
	output logic [DW-1:0]     rem
);
	localparam int CNTW = $clog2(KEY_W + 1);

	logic [KEY_W-1:0] sh_q;
	logic [DW-1:0]    r_q;
	logic [CNTW-1:0]  cnt_q;
	logic             done_q;
	logic [DW:0]      trial;
	logic [DW:0]      diff;

	assign trial = {r_q, sh_q[KEY_W-1]};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNTW'(KEY_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q <= dividend;
			r_q  <= '0;
		end else if (cnt_q != '0) begin
			sh_q <= sh_q << 1;
			r_q  <= (trial >= {1'b0, divisor}) ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = r_q;
endmodule

// ----- rtl/rhlt_store.sv -----
// Slot memory: one write port, one registered read port.
`timescale 1ns / 1ps
module rhlt_store #(
	parameter int DEPTH = 256,
	parameter int AW    = 8,
	parameter int W     = 72
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ----- rtl/robin_hood_lock_table.sv -----
// Top level of the Robin Hood lock table.
`timescale 1ns / 1ps
// Robin Hood lock table. A request (action, key_hash, owner_id) is taken when start is high
// and busy is low; its one result appears on the result ports for a single cycle with done
// high and must be captured then. Each request runs the bit-serial key modulo table_size,
// then a read and an evaluate-and-write-back step for each slot probed or shifted in the slot
// memory (one write port, one registered read port). Action 3 answers after the modulo step.
// The occupancy and statistics ports follow the internal counters and are valid with done.
// A write of table_size empties all slots at once through per-slot valid bits; the user must
// write it only while busy is low, as the block itself does not enforce this.
module robin_hood_lock_table import rhlt_pkg::*; #(
	parameter int TABLE_ENTRIES = 256,
	parameter int OWNER_BITS    = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           action,
	input  logic [KEY_W-1:0]     key_hash,
	input  logic [OWNIN_W-1:0]   owner_id,
	input  logic                 cfg_we,
	input  logic [SIZE_W-1:0]    cfg_data,
	output logic                 done,
	output logic [STAT_W-1:0]    status,
	output logic [SIZE_W-1:0]    position,
	output logic [SIZE_W-1:0]    occupied_count,
	output logic [7:0]           max_probe_length,
	output logic [SIZE_W-1:0]    max_occupied,
	output logic [CNT_W-1:0]     collision_count,
	output logic [CNT_W-1:0]     full_count
);
	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int OW = (OWNER_BITS < OWNIN_W) ? OWNER_BITS : OWNIN_W;
	localparam int EW = KEY_W + OW + CW;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_HASH  = 3'd1;
	localparam logic [2:0] S_RD    = 3'd2;
	localparam logic [2:0] S_EV    = 3'd3;
	localparam logic [2:0] S_SH_RD = 3'd4;
	localparam logic [2:0] S_SH_EV = 3'd5;

	logic [2:0]              state_q;
	logic [1:0]              act_q;
	logic [KEY_W-1:0]        key_q;
	logic [OW-1:0]           own_q;
	logic [SIZE_W-1:0]       tsize_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [CW-1:0]           occ_q, peakp_q, peako_q;
	logic [CNT_W-1:0]        conf_q, fullc_q;
	logic [IW-1:0]           idx_q, free_q;
	logic [CW-1:0]           cnt_q, cp_q;
	logic [KEY_W-1:0]        ck_q;
	logic [OW-1:0]           co_q;
	logic                    disp_q, full_q, done_q;
	logic [STAT_W-1:0]       status_q;
	logic [SIZE_W-1:0]       pos_q;

	logic [CW-1:0]           eff;
	logic [31:0]             ts32;
	logic                    accept;
	logic                    mod_done;
	logic [CW-1:0]           mod_rem;
	logic                    mem_we, mem_re;
	logic [IW-1:0]           mem_waddr;
	logic [EW-1:0]           mem_wdata, mem_rdata;
	logic [KEY_W-1:0]        rk;
	logic [OW-1:0]           ro;
	logic [CW-1:0]           rp;
	logic                    rv;
	logic [CW-1:0]           idx_inc;
	logic [IW-1:0]           idx_nxt;
	logic [CW-1:0]           cnt_inc;

	assign ts32 = {{(32 - SIZE_W){1'b0}}, tsize_q};
	always_comb begin
		if (tsize_q == '0) eff = CW'(1);
		else if (ts32 > 32'(TABLE_ENTRIES)) eff = CW'(TABLE_ENTRIES);
		else eff = CW'(ts32);
	end

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	rhlt_mod #(.DW(CW)) u_mod (
		.clk(clk), .arst_n(arst_n), .start(accept), .dividend(key_hash),
		.divisor(eff), .done(mod_done), .rem(mod_rem)
	);

	assign mem_re = (state_q == S_RD) || (state_q == S_SH_RD);

	rhlt_store #(.DEPTH(TABLE_ENTRIES), .AW(IW), .W(EW)) u_store (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.re(mem_re), .raddr(idx_q), .rdata(mem_rdata)
	);

	assign rk = mem_rdata[EW-1 -: KEY_W];
	assign ro = mem_rdata[CW +: OW];
	assign rp = mem_rdata[CW-1:0];
	assign rv = valid_q[idx_q];

	assign idx_inc = CW'(idx_q) + 1'b1;
	assign idx_nxt = (idx_inc >= eff) ? '0 : idx_inc[IW-1:0];
	assign cnt_inc = cnt_q + 1'b1;

	// write back during lock placement/swap and during the deletion shift
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = {ck_q, co_q, cp_q};
		if (state_q == S_EV && act_q == ACT_LOCK) begin
			if (!rv || (rp < cp_q && disp_q) || (rp < cp_q && !full_q &&
			    !(rk == key_q))) begin
				mem_we = 1'b1;
			end
		end else if (state_q == S_SH_EV && rv && rp != '0) begin
			mem_we    = 1'b1;
			mem_waddr = free_q;
			mem_wdata = {rk, ro, rp - 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			tsize_q  <= SIZE_W'(256);
			valid_q  <= '0;
			occ_q    <= '0;
			peakp_q  <= '0;
			peako_q  <= '0;
			conf_q   <= '0;
			fullc_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				tsize_q <= cfg_data;
				valid_q <= '0;
				occ_q   <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_HASH;
				end
				S_HASH: begin
					if (mod_done) begin
						if (act_q == ACT_LOCK || act_q == ACT_UNLOCK ||
						    act_q == ACT_SEARCH) begin
							state_q <= S_RD;
						end else begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end
					end
				end
				S_RD: state_q <= S_EV;
				S_EV: begin
					if (act_q == ACT_LOCK) begin
						priority if (!rv) begin
							valid_q[idx_q] <= 1'b1;
							occ_q <= occ_q + 1'b1;
							if (cp_q > peakp_q) peakp_q <= cp_q;
							if (occ_q + 1'b1 > peako_q) peako_q <= occ_q + 1'b1;
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end else if (!disp_q && rk == key_q) begin
							if (ro != own_q && conf_q != '1) conf_q <= conf_q + 1'b1;
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end else if ((rp < cp_q && full_q) || cnt_q == eff) begin
							if (fullc_q != '1) fullc_q <= fullc_q + 1'b1;
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end else begin
							state_q <= S_RD;
						end
					end else begin
						priority if (!rv || rp < cnt_q) begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end else if (rk == key_q) begin
							if (act_q == ACT_UNLOCK && ro == own_q) begin
								valid_q[idx_q] <= 1'b0;
								occ_q <= occ_q - 1'b1;
								state_q <= (eff <= CW'(1)) ? S_IDLE : S_SH_RD;
								done_q  <= (eff <= CW'(1));
							end else begin
								state_q <= S_IDLE;
								done_q  <= 1'b1;
							end
						end else if (cnt_inc >= eff) begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_SH_RD: state_q <= S_SH_EV;
				S_SH_EV: begin
					if (!rv || rp == '0) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						valid_q[free_q] <= 1'b1;
						valid_q[idx_q]  <= 1'b0;
						state_q <= (cnt_inc >= eff) ? S_IDLE : S_SH_RD;
						done_q  <= (cnt_inc >= eff);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath: request capture, probe walk, carried entry, result
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
			key_q <= key_hash;
			own_q <= owner_id[OW-1:0];
		end
		unique case (state_q)
			S_HASH: begin
				idx_q  <= mod_rem[IW-1:0];
				cnt_q  <= '0;
				cp_q   <= '0;
				ck_q   <= key_q;
				co_q   <= own_q;
				disp_q <= 1'b0;
				full_q <= (occ_q >= eff);
				pos_q  <= '0;
				status_q <= ST_MISSING;
				if (act_q != ACT_LOCK && act_q != ACT_UNLOCK && act_q != ACT_SEARCH)
					pos_q <= SIZE_W'(eff);
			end
			S_EV: begin
				if (act_q == ACT_LOCK) begin
					priority if (!rv) begin
						status_q <= ST_ACQUIRED;
					end else if (!disp_q && rk == key_q) begin
						status_q <= (ro == own_q) ? ST_HELD : ST_CONFLICT;
					end else if ((rp < cp_q && full_q) || cnt_q == eff) begin
						status_q <= ST_FULL;
					end else begin
						if (rp < cp_q) begin
							ck_q   <= rk;
							co_q   <= ro;
							cp_q   <= rp + 1'b1;
							disp_q <= 1'b1;
						end else begin
							cp_q <= cp_q + 1'b1;
						end
						cnt_q <= cnt_inc;
						idx_q <= idx_nxt;
					end
				end else begin
					priority if (!rv || rp < cnt_q) begin
						status_q <= (act_q == ACT_UNLOCK) ? ST_NOT_HELD : ST_MISSING;
						pos_q    <= SIZE_W'(eff);
					end else if (rk == key_q) begin
						if (act_q == ACT_SEARCH) begin
							status_q <= ST_FOUND;
							pos_q    <= SIZE_W'(idx_q);
						end else begin
							status_q <= (ro == own_q) ? ST_RELEASED : ST_NOT_HELD;
							free_q <= idx_q;
							idx_q  <= idx_nxt;
							cnt_q  <= CW'(1);
						end
					end else begin
						status_q <= (act_q == ACT_UNLOCK) ? ST_NOT_HELD : ST_MISSING;
						pos_q    <= SIZE_W'(eff);
						cnt_q    <= cnt_inc;
						idx_q    <= idx_nxt;
					end
				end
			end
			S_SH_EV: begin
				free_q <= idx_q;
				idx_q  <= idx_nxt;
				cnt_q  <= cnt_inc;
			end
			default: ;
		endcase
		// lock and unlock report position zero
		if (state_q == S_EV && (act_q == ACT_LOCK || act_q == ACT_UNLOCK)) pos_q <= '0;
	end

	assign done             = done_q;
	assign status           = status_q;
	assign position         = pos_q;
	assign occupied_count   = SIZE_W'(occ_q);
	assign max_probe_length = 8'(peakp_q);
	assign max_occupied     = SIZE_W'(peako_q);
	assign collision_count  = conf_q;
	assign full_count       = fullc_q;
endmodule

// ----- rtl/rhlt_checker.sv -----
// Port-level checks for the lock table, bound to the top level.
`timescale 1ns / 1ps
module rhlt_checker import rhlt_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [SIZE_W-1:0] occupied_count,
	input logic [SIZE_W-1:0] max_occupied,
	input logic [CNT_W-1:0]  collision_count
);
	a_one_shot: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe held longer than one cycle");
	a_take: assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("request taken without going busy");
	a_idle_done: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result shown while still busy");
	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		occupied_count <= max_occupied)
		else $error("occupancy above its peak");
	a_mono: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> collision_count >= $past(collision_count))
		else $error("collision count went down");
endmodule

bind robin_hood_lock_table rhlt_checker u_rhlt_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.occupied_count(occupied_count), .max_occupied(max_occupied),
	.collision_count(collision_count)
);

// ----- test/tb_top.sv -----
// Testbench for the Robin Hood lock table: directed table, then randomized predicted requests.
`timescale 1ns / 1ps
module tb_top;
	import rhlt_pkg::*;

	typedef struct packed {
		logic [STAT_W-1:0] st;
		logic [SIZE_W-1:0] pos;
		logic [SIZE_W-1:0] occ;
		logic [7:0]        mpl;
		logic [SIZE_W-1:0] mocc;
		logic [CNT_W-1:0]  coll;
		logic [CNT_W-1:0]  fulls;
	} lock_result_t;

	typedef struct packed {
		logic [1:0]         act;
		logic [KEY_W-1:0]   key;
		logic [OWNIN_W-1:0] own;
		logic               typed;
		logic [STAT_W-1:0]  st;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] action = ACT_LOCK;
	logic [KEY_W-1:0] key_hash = '0;
	logic [OWNIN_W-1:0] owner_id = '0;
	logic cfg_we = 1'b0;
	logic [SIZE_W-1:0] cfg_data = '0;
	logic busy, done;
	logic [STAT_W-1:0] status;
	logic [SIZE_W-1:0] position, occupied_count, max_occupied;
	logic [7:0] max_probe_length;
	logic [CNT_W-1:0] collision_count, full_count;

	robin_hood_lock_table dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .key_hash(key_hash), .owner_id(owner_id),
		.cfg_we(cfg_we), .cfg_data(cfg_data), .done(done), .status(status),
		.position(position), .occupied_count(occupied_count),
		.max_probe_length(max_probe_length), .max_occupied(max_occupied),
		.collision_count(collision_count), .full_count(full_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	logic [KEY_W-1:0]   tbl_key [256];
	logic [OWNIN_W-1:0] tbl_own [256];
	int unsigned        tbl_probe [256];
	bit                 tbl_live [256];
	int unsigned tbl_occ, tbl_peak_probe, tbl_peak_occ, tbl_size;
	logic [CNT_W-1:0] tbl_coll, tbl_full;

	lock_result_t pending_results[$];
	int errors = 0;
	int accepted = 0;
	int results_seen = 0;
	int sender_idle_pct = 0;

	function automatic int unsigned used_slots();
		int unsigned s;
		s = tbl_size;
		if (s < 1) s = 1;
		if (s > 256) s = 256;
		return s;
	endfunction

	function automatic int unsigned step_slot(int unsigned i, int unsigned s);
		return (i + 1 >= s) ? 0 : i + 1;
	endfunction

	function automatic void empty_slots();
		for (int i = 0; i < 256; i++) begin
			tbl_live[i] = 0;
			tbl_key[i] = '0;
			tbl_own[i] = '0;
			tbl_probe[i] = 0;
		end
		tbl_occ = 0;
	endfunction

	function automatic logic [STAT_W-1:0] lock_key(logic [KEY_W-1:0] key,
			logic [OWNIN_W-1:0] own);
		int unsigned s, idx, cp, tp;
		logic [KEY_W-1:0] ck, tk;
		logic [OWNIN_W-1:0] co, tw;
		bit moved, is_full;
		s = used_slots();
		idx = 32'(key % s);
		ck = key;
		co = own;
		cp = 0;
		moved = 0;
		is_full = tbl_occ >= s;
		for (int n = 0; n <= s; n++) begin
			if (!tbl_live[idx]) begin
				tbl_live[idx] = 1;
				tbl_key[idx] = ck;
				tbl_own[idx] = co;
				tbl_probe[idx] = cp;
				tbl_occ++;
				if (cp > tbl_peak_probe) tbl_peak_probe = cp;
				if (tbl_occ > tbl_peak_occ) tbl_peak_occ = tbl_occ;
				return ST_ACQUIRED;
			end
			if (!moved && tbl_key[idx] == key) begin
				if (tbl_own[idx] == own) return ST_HELD;
				if (tbl_coll != '1) tbl_coll++;
				return ST_CONFLICT;
			end
			if (tbl_probe[idx] < cp) begin
				if (is_full) break;
				tk = tbl_key[idx];
				tw = tbl_own[idx];
				tp = tbl_probe[idx];
				tbl_key[idx] = ck;
				tbl_own[idx] = co;
				tbl_probe[idx] = cp;
				ck = tk;
				co = tw;
				cp = tp;
				moved = 1;
			end
			cp++;
			idx = step_slot(idx, s);
		end
		if (tbl_full != '1) tbl_full++;
		return ST_FULL;
	endfunction

	function automatic logic [STAT_W-1:0] unlock_key(logic [KEY_W-1:0] key,
			logic [OWNIN_W-1:0] own);
		int unsigned s, idx, p, hole;
		s = used_slots();
		idx = 32'(key % s);
		for (p = 0; p < s; p++) begin
			if (!tbl_live[idx] || tbl_probe[idx] < p) return ST_NOT_HELD;
			if (tbl_key[idx] == key) break;
			idx = step_slot(idx, s);
		end
		if (p >= s || tbl_own[idx] != own) return ST_NOT_HELD;
		tbl_live[idx] = 0;
		tbl_key[idx] = '0;
		tbl_own[idx] = '0;
		tbl_probe[idx] = 0;
		tbl_occ--;
		hole = idx;
		idx = step_slot(idx, s);
		// shift displaced followers one slot back
		for (p = 1; p < s; p++) begin
			if (!tbl_live[idx] || tbl_probe[idx] == 0) break;
			tbl_live[hole] = 1;
			tbl_key[hole] = tbl_key[idx];
			tbl_own[hole] = tbl_own[idx];
			tbl_probe[hole] = tbl_probe[idx] - 1;
			tbl_live[idx] = 0;
			tbl_key[idx] = '0;
			tbl_own[idx] = '0;
			tbl_probe[idx] = 0;
			hole = idx;
			idx = step_slot(idx, s);
		end
		return ST_RELEASED;
	endfunction

	function automatic lock_result_t predict_request(logic [1:0] act, logic [KEY_W-1:0] key,
			logic [OWNIN_W-1:0] own);
		lock_result_t r;
		int unsigned s, idx;
		r = '0;
		s = used_slots();
		case (act)
			ACT_LOCK: r.st = lock_key(key, own);
			ACT_UNLOCK: r.st = unlock_key(key, own);
			ACT_SEARCH: begin
				r.st = ST_MISSING;
				r.pos = SIZE_W'(s);
				idx = 32'(key % s);
				for (int p = 0; p < s; p++) begin
					if (!tbl_live[idx] || tbl_probe[idx] < p) break;
					if (tbl_key[idx] == key) begin
						r.st = ST_FOUND;
						r.pos = SIZE_W'(idx);
						break;
					end
					idx = step_slot(idx, s);
				end
			end
			default: begin
				r.st = ST_MISSING;
				r.pos = SIZE_W'(s);
			end
		endcase
		r.occ = SIZE_W'(tbl_occ);
		r.mpl = 8'(tbl_peak_probe);
		r.mocc = SIZE_W'(tbl_peak_occ);
		r.coll = tbl_coll;
		r.fulls = tbl_full;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
	endtask

	always @(posedge clk) begin
		lock_result_t w;
		if (done) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, status", status, 0);
			end else begin
				w = pending_results.pop_front();
				if (status !== w.st) report_mismatch("status", status, w.st);
				if (position !== w.pos) report_mismatch("position", position, w.pos);
				if (occupied_count !== w.occ)
					report_mismatch("occupied_count", occupied_count, w.occ);
				if (max_probe_length !== w.mpl)
					report_mismatch("max_probe_length", max_probe_length, w.mpl);
				if (max_occupied !== w.mocc)
					report_mismatch("max_occupied", max_occupied, w.mocc);
				if (collision_count !== w.coll)
					report_mismatch("collision_count", collision_count, w.coll);
				if (full_count !== w.fulls)
					report_mismatch("full_count", full_count, w.fulls);
			end
		end
	end

	// called at a falling edge; returns at a falling edge, with start still high unless the sender pauses
	task automatic send_request(logic [1:0] act, logic [KEY_W-1:0] key, logic [OWNIN_W-1:0] own,
			bit typed, logic [STAT_W-1:0] typed_st);
		lock_result_t r;
		start = 1'b1;
		action = act;
		key_hash = key;
		owner_id = own;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		r = predict_request(act, key, own);
		if (typed) r.st = typed_st;
		pending_results.push_back(r);
		accepted++;
		@(negedge clk);
		if ($urandom_range(99) < sender_idle_pct) begin
			start = 1'b0;
			repeat ($urandom_range(6, 1)) @(negedge clk);
		end
	endtask

	task automatic drain();
		start = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		while (busy) @(negedge clk);
	endtask

	task automatic write_size(logic [SIZE_W-1:0] v);
		drain();
		cfg_we = 1'b1;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 1'b0;
		tbl_size = 32'(v);
		empty_slots();
	endtask

	initial begin
		#20_000_000;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("** robin_hood_lock_table: FAILED **");
		$finish;
	end

	localparam logic [KEY_W-1:0] KMAX = '1;
	dir_row_t dir_rows[20];
	logic [KEY_W-1:0] key_pool[320];
	logic [OWNIN_W-1:0] owner_pool[3];
	int phase_sizes[9] = '{1, 0, 2, 7, 300, 511, 13, 256, 3};
	int phase_items[9] = '{120, 120, 140, 180, 160, 400, 180, 160, 140};

	initial begin
		int pool_n, lock_pct, sent;
		logic [1:0] act;
		logic [KEY_W-1:0] key;
		logic [OWNIN_W-1:0] own;
		dir_rows = '{
			'{ACT_SEARCH, 48'd0, 16'd0, 1'b1, ST_MISSING},
			'{ACT_LOCK, 48'd0, 16'd0, 1'b1, ST_ACQUIRED},
			'{ACT_LOCK, 48'd0, 16'd0, 1'b1, ST_HELD},
			'{ACT_LOCK, 48'd0, 16'hFFFF, 1'b1, ST_CONFLICT},
			'{ACT_LOCK, KMAX, 16'hFFFF, 1'b1, ST_ACQUIRED},
			'{ACT_LOCK, 48'd256, 16'd1, 1'b0, ST_ACQUIRED},
			'{ACT_LOCK, 48'd512, 16'd2, 1'b0, ST_ACQUIRED},
			'{ACT_SEARCH, 48'd512, 16'd9, 1'b0, ST_FOUND},
			'{ACT_UNLOCK, 48'd0, 16'd1, 1'b1, ST_NOT_HELD},
			'{ACT_UNLOCK, 48'd0, 16'd0, 1'b1, ST_RELEASED},
			'{ACT_SEARCH, 48'd256, 16'd0, 1'b0, ST_FOUND},
			'{ACT_SEARCH, 48'd0, 16'd0, 1'b0, ST_MISSING},
			'{2'd3, 48'h123, 16'h5A5A, 1'b1, ST_MISSING},
			'{ACT_UNLOCK, 48'h1234, 16'd5, 1'b1, ST_NOT_HELD},
			'{ACT_LOCK, 48'd1, 16'd7, 1'b0, ST_ACQUIRED},
			'{ACT_LOCK, 48'd257, 16'd7, 1'b0, ST_ACQUIRED},
			'{ACT_SEARCH, 48'd257, 16'd7, 1'b0, ST_FOUND},
			'{ACT_UNLOCK, 48'd256, 16'd1, 1'b0, ST_RELEASED},
			'{ACT_UNLOCK, KMAX, 16'hFFFF, 1'b1, ST_RELEASED},
			'{ACT_SEARCH, KMAX, 16'd0, 1'b0, ST_MISSING}
		};
		tbl_size = 256;
		empty_slots();
		tbl_peak_probe = 0;
		tbl_peak_occ = 0;
		tbl_coll = '0;
		tbl_full = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_request(dir_rows[i].act, dir_rows[i].key, dir_rows[i].own,
				dir_rows[i].typed, dir_rows[i].st);

		sent = 0;
		foreach (phase_sizes[ph]) begin
			write_size(SIZE_W'(phase_sizes[ph]));
			pool_n = (phase_sizes[ph] == 511) ? 320 : 12 + phase_sizes[ph] % 40;
			lock_pct = (phase_sizes[ph] == 511) ? 70 : 55;
			for (int i = 0; i < pool_n; i++) begin
				key_pool[i] = KEY_W'({$urandom, $urandom});
				// cluster keys onto few home slots in the large table
				if (phase_sizes[ph] >= 256) key_pool[i][7:0] = 8'($urandom_range(5));
			end
			foreach (owner_pool[i]) owner_pool[i] = 16'($urandom);
			for (int i = 0; i < phase_items[ph]; i++) begin
				if (sent < 530) sender_idle_pct = 13;
				else if (sent < 1060) sender_idle_pct = 53;
				else sender_idle_pct = 0;
				if (i == phase_items[ph] / 2) drain();
				case ($urandom_range(99)) inside
					[0:lock_pct-1]: act = ACT_LOCK;
					[lock_pct:lock_pct+24]: act = ACT_UNLOCK;
					[lock_pct+25:96]: act = ACT_SEARCH;
					default: act = 2'd3;
				endcase
				key = ($urandom_range(9) == 0) ? KEY_W'({$urandom, $urandom}) :
					key_pool[$urandom_range(pool_n - 1)];
				own = ($urandom_range(9) == 0) ? 16'($urandom) :
					owner_pool[$urandom_range(2)];
				send_request(act, key, own, 1'b0, ST_ACQUIRED);
				sent++;
			end
		end

		drain();
		repeat (200) @(negedge clk);
		$display("covered %0d requests (%0d results) over %0d table sizes incl. 0, 1 and oversize",
			accepted, results_seen, 9);
		$display("peak probe %0d, peak occupancy %0d, conflicts %0d, full refusals %0d",
			tbl_peak_probe, tbl_peak_occ, tbl_coll, tbl_full);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("** robin_hood_lock_table: PASSED **");
		end else begin
			$display("** robin_hood_lock_table: FAILED **");
		end
		$finish;
	end
endmodule
